// File: hdl/ufs_pkg.sv
// Shared widths, action codes and saturation helpers for the upwind face flux block.
`timescale 1ns / 1ps

package ufs_pkg;

    localparam int DATA_W         = 32;
    localparam int IDX_W          = 10;
    localparam int ACT_W          = 2;
    localparam int CELL_COUNT_DEF = 1024;

    localparam int IN_DATA_W  = 224;
    localparam int OUT_DATA_W = 160;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_FACE  = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    localparam logic signed [64:0] Q_MAX_W = 65'sd2147483647;
    localparam logic signed [64:0] Q_MIN_W = -65'sd2147483648;

    // Clamp a wide signed value into signed 32 bits.
    function automatic logic signed [DATA_W-1:0] sat_q(input logic signed [64:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > Q_MAX_W) begin
            r = 32'sh7fffffff;
        end else if (v < Q_MIN_W) begin
            r = 32'sh80000000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/upwind_face_flux_source_update.sv
// Upwind face flux block: cell position and source tables with face read-modify-write.
`timescale 1ns / 1ps
//
// Input channel s_axis_*: one item per handshake; s_axis_tuser carries the action
// (write cell, process face, read cell), s_axis_tdata the remaining fields.
// Output channel m_axis_*: exactly one result item per input item, in order.
// A face item needs only one cell: the owner when the mass flux is not negative,
// else the neighbour, because the other flux part is zero. That cell's position
// and source are read from the tables, the source is updated and written back.
// An accepted item passes the calc and final stages into the output register.
// A new item is taken only when the last is in its final stage, set by the source
// table read-modify-write (read in the accept cycle, multiply and write back next).
// The product of flux and distance is registered before rounding and clamping.
// Reset clears the control state and the output valid; the tables hold no reset
// value and must be written before a face or read refers to them.
// When the receiver stalls, the result holds in the output register; one more
// item may be accepted and then waits in its final stage until the output frees.
module upwind_face_flux_source_update
    import ufs_pkg::*;
#(
    parameter int CELL_COUNT = CELL_COUNT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [9:0] cell_index, [41:10] cell_position_value, [73:42] cell_source_value,
    // [83:74] owner_cell, [93:84] neighbour_cell, [125:94] mass_flux,
    // [157:126] face_position, [189:158] rface0_in, [221:190] rface1_in, rest zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  logic [ACT_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] face_coeff, [63:32] rface0_out, [95:64] rface1_out,
    // [127:96] read_position, [159:128] read_source
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int ADDR_W    = $clog2(CELL_COUNT);
    localparam int IDX_EXT_W = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
    localparam logic signed [64:0] ROUND_HALF = 65'sd32768;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_FIN
    } state_t;

    // input field unpacking
    logic        [IDX_W-1:0]  in_cell_index;
    logic signed [DATA_W-1:0] in_pos_value;
    logic signed [DATA_W-1:0] in_src_value;
    logic        [IDX_W-1:0]  in_owner;
    logic        [IDX_W-1:0]  in_neighbour;
    logic signed [DATA_W-1:0] in_mass_flux;
    logic signed [DATA_W-1:0] in_face_pos;
    logic signed [DATA_W-1:0] in_rface0;
    logic signed [DATA_W-1:0] in_rface1;
    action_t                  in_action;

    assign in_cell_index = s_axis_tdata[9:0];
    assign in_pos_value  = s_axis_tdata[41:10];
    assign in_src_value  = s_axis_tdata[73:42];
    assign in_owner      = s_axis_tdata[83:74];
    assign in_neighbour  = s_axis_tdata[93:84];
    assign in_mass_flux  = s_axis_tdata[125:94];
    assign in_face_pos   = s_axis_tdata[157:126];
    assign in_rface0     = s_axis_tdata[189:158];
    assign in_rface1     = s_axis_tdata[221:190];
    assign in_action     = action_t'(s_axis_tuser);

    state_t state_reg, state_next;
    logic   in_acc;
    logic   out_free;

    // item registers
    action_t                  act_reg;
    logic                     idx_ok_reg;
    logic        [ADDR_W-1:0] addr_reg;
    logic signed [DATA_W-1:0] m_reg;
    logic signed [DATA_W-1:0] fx_reg;
    logic signed [DATA_W-1:0] r0_reg;
    logic signed [DATA_W-1:0] r1_reg;
    logic signed [DATA_W-1:0] wpos_reg;
    logic signed [DATA_W-1:0] wsrc_reg;

    // table storage and read data
    logic signed [DATA_W-1:0] pos_mem [CELL_COUNT];
    logic signed [DATA_W-1:0] src_mem [CELL_COUNT];
    logic signed [DATA_W-1:0] pos_rd_reg;
    logic signed [DATA_W-1:0] src_rd_reg;

    // stage results
    logic signed [64:0]       prod_reg;
    logic signed [DATA_W-1:0] rp_reg;
    logic signed [DATA_W-1:0] rs_reg;
    logic                     out_valid_reg;
    logic [OUT_DATA_W-1:0]    out_data_reg;

    // address selection for the accepted item
    logic [IDX_W-1:0]     sel_index;
    logic [IDX_EXT_W-1:0] sel_ext;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 rd_ok;

    always_comb
    begin
        if (in_action == ACT_FACE) begin
            sel_index = in_mass_flux[DATA_W-1] ? in_neighbour : in_owner;
        end else begin
            sel_index = in_cell_index;
        end
        sel_ext = IDX_EXT_W'(sel_index);
        rd_addr = sel_ext[ADDR_W-1:0];
        rd_ok   = (32'(sel_index) < 32'(CELL_COUNT));
    end

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) || ((state_reg == ST_FIN) && out_free);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // calc stage arithmetic
    logic signed [DATA_W-1:0] pos_val;
    logic signed [32:0]       diff;
    logic signed [32:0]       flux_mag;
    logic signed [33:0]       src_sum;
    logic signed [64:0]       prod_next;
    logic                     src_we;
    logic                     pos_we;

    always_comb
    begin
        pos_val   = idx_ok_reg ? pos_rd_reg : '0;
        diff      = 33'(fx_reg) - 33'(pos_val);
        prod_next = 65'(m_reg) * 65'(diff);
        flux_mag  = m_reg[DATA_W-1] ? -33'(m_reg) : 33'(m_reg);
        src_sum   = 34'(src_rd_reg) + 34'(flux_mag);
        pos_we    = (state_reg == ST_CALC) && idx_ok_reg && (act_reg == ACT_WRITE);
        src_we    = (state_reg == ST_CALC) && idx_ok_reg &&
                    ((act_reg == ACT_WRITE) || (act_reg == ACT_FACE));
    end

    // final stage arithmetic
    logic signed [64:0]       prod_rnd;
    logic signed [DATA_W-1:0] coeff_val;
    logic signed [DATA_W-1:0] r0_val;
    logic signed [DATA_W-1:0] r1_val;
    logic signed [DATA_W-1:0] p_part;
    logic signed [DATA_W-1:0] n_part;
    logic [OUT_DATA_W-1:0]    result_data;

    always_comb
    begin
        prod_rnd  = (prod_reg + ROUND_HALF) >>> 16;
        coeff_val = sat_q(prod_rnd);
        p_part    = m_reg[DATA_W-1] ? '0 : m_reg;
        n_part    = m_reg[DATA_W-1] ? m_reg : '0;
        r0_val    = sat_q(65'(r0_reg) - 65'(p_part));
        r1_val    = sat_q(65'(r1_reg) + 65'(n_part));
        case (act_reg)
            ACT_FACE:
            begin
                result_data = {32'd0, 32'd0, r1_val, r0_val, coeff_val};
            end
            ACT_READ:
            begin
                result_data = {rs_reg, rp_reg, 32'd0, 32'd0, 32'd0};
            end
            default:
            begin
                result_data = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free) begin
                    state_next = in_acc ? ST_CALC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_FIN) && out_free) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= result_data;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the accepted item
    always_ff @(posedge clk)
    begin
        if (in_acc) begin
            act_reg    <= in_action;
            idx_ok_reg <= rd_ok;
            addr_reg   <= rd_addr;
            m_reg      <= in_mass_flux;
            fx_reg     <= in_face_pos;
            r0_reg     <= in_rface0;
            r1_reg     <= in_rface1;
            wpos_reg   <= in_pos_value;
            wsrc_reg   <= in_src_value;
        end
        if (state_reg == ST_CALC) begin
            prod_reg <= prod_next;
            rp_reg   <= idx_ok_reg ? pos_rd_reg : '0;
            rs_reg   <= idx_ok_reg ? src_rd_reg : '0;
        end
    end

    // position table: read on accept, write in the calc cycle
    always_ff @(posedge clk)
    begin
        if (in_acc) begin
            pos_rd_reg <= pos_mem[rd_addr];
        end
        if (pos_we) begin
            pos_mem[addr_reg] <= wpos_reg;
        end
    end

    // source table: read on accept, write back the update in the calc cycle
    always_ff @(posedge clk)
    begin
        if (in_acc) begin
            src_rd_reg <= src_mem[rd_addr];
        end
        if (src_we) begin
            src_mem[addr_reg] <= (act_reg == ACT_WRITE) ? wsrc_reg : sat_q(65'(src_sum));
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // no item is taken while the table write-back is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) |-> !s_axis_tready)
        else $error("item accepted during table write-back");

    // an accepted item always enters the calc stage next
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == ST_CALC))
        else $error("accepted item did not reach calc stage");

    // a finished item waits while the output register is occupied and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FIN) && !out_free) |=> (state_reg == ST_FIN) && m_axis_tvalid)
        else $error("finished item lost under output stall");

    // the table is written only with the calc stage active
    assert property (@(posedge clk) disable iff (!rst_n)
        (src_we || pos_we) |-> ($past(in_acc) || $past(state_reg) == ST_IDLE
                               || $past(state_reg) == ST_FIN))
        else $error("table write outside calc stage");

endmodule
